// ----- sv/mpsm_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the multi-pattern string matcher
// no dependencies

package mpsm_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int MODE_W     = 3;
   localparam int LETTER_W   = 5;
   localparam int POS_W      = 16;

   localparam logic [MODE_W-1:0] MODE_PATTERN = 3'd0;
   localparam logic [MODE_W-1:0] MODE_END     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BUILD   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TEXT    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

   localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

   typedef enum logic [19:0] {
      ST_INIT     = 20'h00001,
      ST_IDLE     = 20'h00002,
      ST_INS_RD   = 20'h00004,
      ST_INS_EV   = 20'h00008,
      ST_INS_NEW  = 20'h00010,
      ST_END_WR   = 20'h00020,
      ST_TXT_RD   = 20'h00040,
      ST_TXT_EV   = 20'h00080,
      ST_TXT_MK   = 20'h00100,
      ST_TXT_OUT  = 20'h00200,
      ST_B_ROOT   = 20'h00400,
      ST_B_ROOTWR = 20'h00800,
      ST_B_POP    = 20'h01000,
      ST_B_NODE   = 20'h02000,
      ST_B_ROW    = 20'h04000,
      ST_B_KID    = 20'h08000,
      ST_CH_RD    = 20'h10000,
      ST_CH_EV    = 20'h20000,
      ST_B_MK     = 20'h40000,
      ST_RESP     = 20'h80000
   } state_type;

endpackage

// ----- sv/multi_pattern_string_matcher.sv -----
`timescale 1ns / 1ps
// aho-corasick matcher top level: sequencer, node tables and build queue
// depends on mpsm_pkg

// Aho-Corasick matcher over an alphabet of ALPHABET letters with a trie of
// NODE_COUNT nodes. Every request item gives exactly one response item. Modes:
// pattern letter, end of pattern, build failure links (also restarts text),
// text letter (reports whether any pattern ends there), clear. One item is
// handled at a time; req_tready is low while an item is in work. All steps
// share the single-ported node tables. A text letter follows failure links
// until it finds an edge for the letter or reaches the root; a letter outside
// the alphabet goes back to the root. A pattern letter makes a node, follows
// an edge, sets the status when the table is full, or is ignored. A build
// walks the trie breadth-first and sets each child's failure link and match
// mark. After reset the block sets up the root before it takes items. There
// is no clearing pass over the tables: a node's row, failure link and marks
// are zeroed when that node is allocated, and only allocated nodes are ever
// read.
module multi_pattern_string_matcher #(
   parameter int NODE_COUNT = 1024,
   parameter int ALPHABET   = 26
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] mode, [7:3] letter
   input  logic [mpsm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] match, [16:1] position, [17] status, [23:18] zero
   output logic [mpsm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int LW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int CW = $clog2(ALPHABET + 1);

   typedef logic [ALPHABET-1:0][NW-1:0] row_type;

   // node tables
   row_type          child_mem [NODE_COUNT];
   logic [NW-1:0]    fail_mem  [NODE_COUNT];
   logic             end_mem   [NODE_COUNT];
   logic             match_mem [NODE_COUNT];
   logic [NW-1:0]    queue_mem [NODE_COUNT];

   row_type          child_rd_ff;
   logic [NW-1:0]    fail_rd_ff, queue_rd_ff;
   logic             end_rd_ff, match_rd_ff;

   logic             child_we, fail_we, end_we, match_we, queue_we;
   logic [NW-1:0]    child_wa, fail_wa, end_wa, match_wa, queue_wa;
   row_type          child_wd;
   logic [NW-1:0]    fail_wd, queue_wd;
   logic             end_wd, match_wd;
   logic [NW-1:0]    child_ra, fail_ra, end_ra, match_ra, queue_ra;

   mpsm_pkg::state_type state_ff, state_in;

   logic [mpsm_pkg::LETTER_W-1:0] letter_ff, letter_in;
   logic [NW:0]      total_ff, total_in;
   logic [NW-1:0]    ins_ff, ins_in;
   logic [NW-1:0]    search_ff, search_in;
   logic [mpsm_pkg::POS_W-1:0] textpos_ff, textpos_in;
   logic             drop_ff, drop_in;
   logic             item_ff, item_in;
   logic [NW-1:0]    walk_ff, walk_in;      // chase cursor, text or build
   logic [NW-1:0]    node_ff, node_in;      // node being expanded by the build
   logic [NW-1:0]    nfail_ff, nfail_in;
   logic [NW-1:0]    target_ff, target_in;
   row_type          row_ff, row_in;
   logic [CW-1:0]    slot_ff, slot_in;
   logic [NW:0]      head_ff, head_in, tail_ff, tail_in;
   logic             res_match_ff, res_match_in;
   logic [mpsm_pkg::POS_W-1:0] res_pos_ff, res_pos_in;
   logic             res_stat_ff, res_stat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [mpsm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   // mark step phase: read phase, then write phase
   logic             mark_ph_ff, mark_ph_in;

   logic [mpsm_pkg::MODE_W-1:0]   req_mode;
   logic [mpsm_pkg::LETTER_W-1:0] req_letter;
   logic             letter_ok;
   logic [LW-1:0]    letter_idx, slot_idx;
   logic [NW-1:0]    kid;
   logic [NW-1:0]    new_node;
   row_type          row_upd;

   assign req_mode   = req_tdata[mpsm_pkg::MODE_W-1:0];
   assign req_letter = req_tdata[mpsm_pkg::MODE_W +: mpsm_pkg::LETTER_W];
   assign letter_idx = LW'(letter_ff);
   assign slot_idx   = LW'(slot_ff);
   assign kid        = row_ff[slot_idx];
   assign new_node   = total_ff[NW-1:0];
   assign mark_ph_in = (state_ff == mpsm_pkg::ST_B_MK) && !mark_ph_ff;

   assign req_tready = (state_ff == mpsm_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      letter_ok = ({4'b0, req_letter} < 9'(ALPHABET));
      row_upd = child_rd_ff;
      row_upd[letter_idx] = new_node;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      letter_in    = letter_ff;
      total_in     = total_ff;
      ins_in       = ins_ff;
      search_in    = search_ff;
      textpos_in   = textpos_ff;
      drop_in      = drop_ff;
      item_in      = item_ff;
      walk_in      = walk_ff;
      node_in      = node_ff;
      nfail_in     = nfail_ff;
      target_in    = target_ff;
      row_in       = row_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      res_match_in = res_match_ff;
      res_pos_in   = res_pos_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      child_we = 1'b0; child_wa = '0; child_wd = '0; child_ra = '0;
      fail_we  = 1'b0; fail_wa  = '0; fail_wd  = '0; fail_ra  = '0;
      end_we   = 1'b0; end_wa   = '0; end_wd   = 1'b0; end_ra = '0;
      match_we = 1'b0; match_wa = '0; match_wd = 1'b0; match_ra = '0;
      queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_ra = '0;

      unique case (state_ff)
         mpsm_pkg::ST_INIT: begin
            // root row and marks, then counters back to the empty trie
            child_we = 1'b1;
            fail_we  = 1'b1;
            end_we   = 1'b1;
            match_we = 1'b1;
            total_in   = (NW+1)'(1);
            ins_in     = '0;
            search_in  = '0;
            textpos_in = '0;
            drop_in    = 1'b0;
            state_in   = item_ff ? mpsm_pkg::ST_RESP : mpsm_pkg::ST_IDLE;
         end
         mpsm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               letter_in    = req_letter;
               item_in      = 1'b1;
               res_match_in = 1'b0;
               res_pos_in   = textpos_ff;
               res_stat_in  = drop_ff;
               case (req_mode)
                  mpsm_pkg::MODE_PATTERN: begin
                     state_in = (drop_ff || !letter_ok) ? mpsm_pkg::ST_RESP
                                                       : mpsm_pkg::ST_INS_RD;
                  end
                  mpsm_pkg::MODE_END: state_in = mpsm_pkg::ST_END_WR;
                  mpsm_pkg::MODE_BUILD: state_in = mpsm_pkg::ST_B_ROOT;
                  mpsm_pkg::MODE_TEXT: begin
                     // a letter outside the alphabet drops back to the root
                     walk_in  = letter_ok ? search_ff : '0;
                     state_in = letter_ok ? mpsm_pkg::ST_TXT_RD : mpsm_pkg::ST_TXT_MK;
                  end
                  mpsm_pkg::MODE_CLEAR: begin
                     res_pos_in  = '0;
                     res_stat_in = 1'b0;
                     state_in    = mpsm_pkg::ST_INIT;
                  end
                  default: state_in = mpsm_pkg::ST_RESP;
               endcase
            end
         end
         mpsm_pkg::ST_INS_RD: begin
            child_ra = ins_ff;
            state_in = mpsm_pkg::ST_INS_EV;
         end
         mpsm_pkg::ST_INS_EV: begin
            if (child_rd_ff[letter_idx] != '0) begin
               ins_in   = child_rd_ff[letter_idx];
               state_in = mpsm_pkg::ST_RESP;
            end else if (total_ff >= (NW+1)'(NODE_COUNT)) begin
               drop_in     = 1'b1;
               res_stat_in = 1'b1;
               state_in    = mpsm_pkg::ST_RESP;
            end else begin
               child_we = 1'b1;
               child_wa = ins_ff;
               child_wd = row_upd;
               state_in = mpsm_pkg::ST_INS_NEW;
            end
         end
         mpsm_pkg::ST_INS_NEW: begin
            // fresh node: empty row, root link, no marks
            child_we = 1'b1; child_wa = new_node;
            fail_we  = 1'b1; fail_wa  = new_node;
            end_we   = 1'b1; end_wa   = new_node;
            match_we = 1'b1; match_wa = new_node;
            ins_in   = new_node;
            total_in = total_ff + (NW+1)'(1);
            state_in = mpsm_pkg::ST_RESP;
         end
         mpsm_pkg::ST_END_WR: begin
            end_we   = !drop_ff;
            end_wa   = ins_ff;
            end_wd   = 1'b1;
            ins_in   = '0;
            drop_in  = 1'b0;
            state_in = mpsm_pkg::ST_RESP;
         end
         mpsm_pkg::ST_TXT_RD: begin
            child_ra = walk_ff;
            fail_ra  = walk_ff;
            state_in = mpsm_pkg::ST_TXT_EV;
         end
         mpsm_pkg::ST_TXT_EV: begin
            if (walk_ff != '0 && child_rd_ff[letter_idx] == '0) begin
               walk_in  = fail_rd_ff;
               state_in = mpsm_pkg::ST_TXT_RD;
            end else begin
               walk_in  = child_rd_ff[letter_idx];
               state_in = mpsm_pkg::ST_TXT_MK;
            end
         end
         mpsm_pkg::ST_TXT_MK: begin
            match_ra = walk_ff;
            state_in = mpsm_pkg::ST_TXT_OUT;
         end
         mpsm_pkg::ST_TXT_OUT: begin
            res_match_in = match_rd_ff;
            search_in    = walk_ff;
            if (textpos_ff != mpsm_pkg::POS_MAX) begin
               textpos_in = textpos_ff + 1'b1;
            end
            state_in = mpsm_pkg::ST_RESP;
         end
         mpsm_pkg::ST_B_ROOT: begin
            end_ra   = '0;
            state_in = mpsm_pkg::ST_B_ROOTWR;
         end
         mpsm_pkg::ST_B_ROOTWR: begin
            fail_we  = 1'b1;
            match_we = 1'b1;
            match_wd = end_rd_ff;
            queue_we = 1'b1;
            head_in  = '0;
            tail_in  = (NW+1)'(1);
            state_in = mpsm_pkg::ST_B_POP;
         end
         mpsm_pkg::ST_B_POP: begin
            if (head_ff == tail_ff) begin
               ins_in      = '0;
               drop_in     = 1'b0;
               search_in   = '0;
               textpos_in  = '0;
               res_pos_in  = '0;
               res_stat_in = 1'b0;
               state_in    = mpsm_pkg::ST_RESP;
            end else begin
               queue_ra = head_ff[NW-1:0];
               head_in  = head_ff + (NW+1)'(1);
               state_in = mpsm_pkg::ST_B_NODE;
            end
         end
         mpsm_pkg::ST_B_NODE: begin
            child_ra = queue_rd_ff;
            fail_ra  = queue_rd_ff;
            node_in  = queue_rd_ff;
            slot_in  = '0;
            state_in = mpsm_pkg::ST_B_ROW;
         end
         mpsm_pkg::ST_B_ROW: begin
            row_in   = child_rd_ff;
            nfail_in = fail_rd_ff;
            state_in = mpsm_pkg::ST_B_KID;
         end
         mpsm_pkg::ST_B_KID: begin
            if (slot_ff == CW'(ALPHABET)) begin
               state_in = mpsm_pkg::ST_B_POP;
            end else if (kid == '0) begin
               slot_in = slot_ff + 1'b1;
            end else if (node_ff == '0) begin
               target_in = '0;
               state_in  = mpsm_pkg::ST_B_MK;
            end else begin
               walk_in  = nfail_ff;
               state_in = mpsm_pkg::ST_CH_RD;
            end
         end
         mpsm_pkg::ST_CH_RD: begin
            child_ra = walk_ff;
            fail_ra  = walk_ff;
            state_in = mpsm_pkg::ST_CH_EV;
         end
         mpsm_pkg::ST_CH_EV: begin
            if (walk_ff != '0 && child_rd_ff[slot_idx] == '0) begin
               walk_in  = fail_rd_ff;
               state_in = mpsm_pkg::ST_CH_RD;
            end else begin
               // a node never fails to itself
               target_in = (child_rd_ff[slot_idx] == kid) ? '0 : child_rd_ff[slot_idx];
               state_in  = mpsm_pkg::ST_B_MK;
            end
         end
         mpsm_pkg::ST_B_MK: begin
            if (!mark_ph_ff) begin
               // read the child's end mark and the failure node's match mark
               end_ra   = kid;
               match_ra = target_ff;
            end else begin
               // write link and mark, queue the child
               fail_we  = 1'b1; fail_wa  = kid; fail_wd = target_ff;
               match_we = 1'b1; match_wa = kid; match_wd = end_rd_ff | match_rd_ff;
               if (tail_ff < (NW+1)'(NODE_COUNT)) begin
                  queue_we = 1'b1;
                  queue_wa = tail_ff[NW-1:0];
                  queue_wd = kid;
                  tail_in  = tail_ff + (NW+1)'(1);
               end
               slot_in  = slot_ff + 1'b1;
               state_in = mpsm_pkg::ST_B_KID;
            end
         end
         mpsm_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(mpsm_pkg::RSP_DATA_W - mpsm_pkg::POS_W - 2){1'b0}},
                               res_stat_ff, res_pos_ff, res_match_ff};
               item_in      = 1'b0;
               state_in     = mpsm_pkg::ST_IDLE;
            end
         end
         default: state_in = mpsm_pkg::ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpsm_pkg::ST_INIT;
         item_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mark_ph_ff   <= 1'b0;
         total_ff     <= (NW+1)'(1);
         ins_ff       <= '0;
         search_ff    <= '0;
         textpos_ff   <= '0;
         drop_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
         mark_ph_ff   <= mark_ph_in;
         total_ff     <= total_in;
         ins_ff       <= ins_in;
         search_ff    <= search_in;
         textpos_ff   <= textpos_in;
         drop_ff      <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff    <= letter_in;
      walk_ff      <= walk_in;
      node_ff      <= node_in;
      nfail_ff     <= nfail_in;
      target_ff    <= target_in;
      row_ff       <= row_in;
      slot_ff      <= slot_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      res_match_ff <= res_match_in;
      res_pos_ff   <= res_pos_in;
      res_stat_ff  <= res_stat_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // single-port style tables, registered reads
   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_wa] <= child_wd;
      end
      child_rd_ff <= child_mem[child_ra];
   end

   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[fail_wa] <= fail_wd;
      end
      fail_rd_ff <= fail_mem[fail_ra];
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[end_wa] <= end_wd;
      end
      end_rd_ff <= end_mem[end_ra];
   end

   always_ff @(posedge clock) begin
      if (match_we) begin
         match_mem[match_wa] <= match_wd;
      end
      match_rd_ff <= match_mem[match_ra];
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_wa] <= queue_wd;
      end
      queue_rd_ff <= queue_mem[queue_ra];
   end

endmodule

// ----- sv/mpsm_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the matcher, bound to the top level
// depends on mpsm_pkg and multi_pattern_string_matcher

module mpsm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [mpsm_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mpsm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // root setup runs right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("ready right after reset");

   // one item at a time: busy once an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/mpsm_checker.sv -----
`timescale 1ns / 1ps
// response checker for the multi-pattern string matcher: watches both streams,
// predicts every response item and compares it; depends on mpsm_pkg

module mpsm_scoreboard #(
   parameter int NODE_COUNT = 1024,
   parameter int ALPHABET   = 26
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mpsm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mpsm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              pending
);

   typedef struct packed {
      logic                       match;
      logic [mpsm_pkg::POS_W-1:0] position;
      logic                       status;
   } verdict_type;

   int          kids [NODE_COUNT][ALPHABET];
   int          fail_of [NODE_COUNT];
   logic        end_of [NODE_COUNT];
   logic        hit_of [NODE_COUNT];
   int          bfs_order [NODE_COUNT];
   int          nodes_used;
   int          pat_node;
   int          text_node;
   logic [15:0] text_index;
   logic        dropped;
   verdict_type expected_q [$];

   task automatic wipe_trie();
      for (int n = 0; n < NODE_COUNT; n++) begin
         for (int c = 0; c < ALPHABET; c++) kids[n][c] = 0;
         fail_of[n] = 0;
         end_of[n]  = 1'b0;
         hit_of[n]  = 1'b0;
      end
      nodes_used = 1;
      pat_node   = 0;
      text_node  = 0;
      text_index = '0;
      dropped    = 1'b0;
   endtask

   // breadth-first walk setting failure links and suffix match marks
   task automatic link_trie();
      int head, tail, node, f, steps, target, kid;
      head = 0;
      tail = 1;
      fail_of[0] = 0;
      hit_of[0]  = end_of[0];
      bfs_order[0] = 0;
      while (head < tail) begin
         node = bfs_order[head];
         head++;
         for (int c = 0; c < ALPHABET; c++) begin
            kid = kids[node][c];
            if (kid != 0) begin
               target = 0;
               if (node != 0) begin
                  f = fail_of[node];
                  steps = 0;
                  while (f != 0 && kids[f][c] == 0 && steps < NODE_COUNT) begin
                     f = fail_of[f];
                     steps++;
                  end
                  target = kids[f][c];
                  if (target == kid) target = 0;
               end
               fail_of[kid] = target;
               hit_of[kid]  = end_of[kid] | hit_of[target];
               if (tail < NODE_COUNT) begin
                  bfs_order[tail] = kid;
                  tail++;
               end
            end
         end
      end
      pat_node   = 0;
      dropped    = 1'b0;
      text_node  = 0;
      text_index = '0;
   endtask

   task automatic predict_item(input logic [mpsm_pkg::MODE_W-1:0] mode,
                               input logic [mpsm_pkg::LETTER_W-1:0] letter);
      verdict_type v;
      int node, steps;
      v.match    = 1'b0;
      v.position = text_index;
      v.status   = dropped;
      case (mode)
         mpsm_pkg::MODE_PATTERN: begin
            if (!dropped && letter < ALPHABET) begin
               if (kids[pat_node][letter] == 0) begin
                  if (nodes_used >= NODE_COUNT) begin
                     dropped = 1'b1;
                  end else begin
                     kids[pat_node][letter] = nodes_used;
                     pat_node = nodes_used;
                     nodes_used++;
                  end
               end else begin
                  pat_node = kids[pat_node][letter];
               end
            end
            v.status = dropped;
         end
         mpsm_pkg::MODE_END: begin
            if (!dropped) end_of[pat_node] = 1'b1;
            pat_node = 0;
            dropped  = 1'b0;
         end
         mpsm_pkg::MODE_BUILD: begin
            link_trie();
            v.position = '0;
            v.status   = 1'b0;
         end
         mpsm_pkg::MODE_TEXT: begin
            node = text_node;
            if (letter >= ALPHABET) begin
               node = 0;
            end else begin
               steps = 0;
               while (node != 0 && kids[node][letter] == 0 && steps < NODE_COUNT) begin
                  node = fail_of[node];
                  steps++;
               end
               node = kids[node][letter];
            end
            text_node = node;
            v.match = hit_of[node];
            if (text_index != mpsm_pkg::POS_MAX) text_index++;
         end
         mpsm_pkg::MODE_CLEAR: begin
            wipe_trie();
            v.position = '0;
            v.status   = 1'b0;
         end
         default: ;
      endcase
      expected_q.push_back(v);
   endtask

   always @(posedge clock) begin
      verdict_type want, got;
      if (reset) begin
         wipe_trie();
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_item(req_tdata[mpsm_pkg::MODE_W-1:0],
                         req_tdata[mpsm_pkg::MODE_W +: mpsm_pkg::LETTER_W]);
         if (rsp_tvalid && rsp_tready) begin
            got.match    = rsp_tdata[0];
            got.position = rsp_tdata[16:1];
            got.status   = rsp_tdata[17];
            if (expected_q.size() == 0) begin
               $display("%0t: response item with none expected: %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got.match !== want.match || got.position !== want.position ||
                   got.status !== want.status || rsp_tdata[23:18] !== '0) begin
                  $display("%0t: mismatch exp match=%0d pos=%0d status=%0d,",
                           $time, want.match, want.position, want.status);
                  $display("   got match=%0d pos=%0d status=%0d pad=%h",
                           got.match, got.position, got.status, rsp_tdata[23:18]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// top of the matcher testbench: clock, reset, stimulus and verdict
// depends on mpsm_pkg, mpsm_scoreboard and the matcher rtl

module testbench;

   localparam int STALL_LIMIT = 200000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mpsm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mpsm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                              fail_count;
   int                              pending;

   int send_idle_pct = 0;  // chance the sender skips a cycle
   int recv_stall_pct = 0; // chance the receiver holds off a cycle
   bit hold_off_req = 0;   // asks the receiver for one long hold-off
   bit hold_off_done = 0;  // set by the receiver once it is over
   int quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   multi_pattern_string_matcher dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   mpsm_scoreboard u_scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_off_done = 1'b1;
         end
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // offer one item at the falling edge and hold it until accepted
   task automatic send_item(input logic [mpsm_pkg::MODE_W-1:0] mode,
                            input logic [mpsm_pkg::LETTER_W-1:0] letter);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {letter, mode};
      while (!req_tready) @(negedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_word(input string word, input logic [mpsm_pkg::MODE_W-1:0] mode);
      for (int i = 0; i < word.len(); i++) send_item(mode, 5'(word[i] - "a"));
   endtask

   // random pattern over letters up to top_letter, usually a narrow range, so texts hit it often
   task automatic random_pattern(input int top_letter);
      int n;
      n = $urandom_range(4);
      for (int i = 0; i < n; i++)
         send_item(mpsm_pkg::MODE_PATTERN, 5'($urandom_range(top_letter)));
      send_item(mpsm_pkg::MODE_END, 5'($urandom_range(31)));
   endtask

   task automatic random_session(input int items);
      int sent, top_letter, n, pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         top_letter = ($urandom_range(3) == 0) ? 25 : $urandom_range(3, 1);
         if (pick < 8) begin
            send_item(mpsm_pkg::MODE_CLEAR, 5'($urandom_range(31)));
            sent++;
         end else if (pick < 12) begin
            // noise: an unused mode and an out-of-alphabet pattern letter
            send_item(3'($urandom_range(7, 5)), 5'($urandom_range(31)));
            send_item(mpsm_pkg::MODE_PATTERN, 5'($urandom_range(31, 26)));
            sent += 2;
         end else begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) random_pattern(top_letter);
            if ($urandom_range(9) != 0)
               send_item(mpsm_pkg::MODE_BUILD, 5'($urandom_range(31)));
            n = $urandom_range(12, 3);
            for (int i = 0; i < n; i++)
               send_item(mpsm_pkg::MODE_TEXT,
                         5'(($urandom_range(19) == 0) ? $urandom_range(31, 26)
                                                      : $urandom_range(top_letter)));
            sent += 10 + n;
         end
      end
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: he/she/hers set, suffix patterns, empty pattern
      send_item(mpsm_pkg::MODE_TEXT, 5'd7);               // text before any build
      send_word("he", mpsm_pkg::MODE_PATTERN);  send_item(mpsm_pkg::MODE_END, 5'd0);
      send_word("she", mpsm_pkg::MODE_PATTERN); send_item(mpsm_pkg::MODE_END, 5'd31);
      send_word("hers", mpsm_pkg::MODE_PATTERN);
      send_item(mpsm_pkg::MODE_PATTERN, 5'd31);           // out-of-alphabet letter ignored
      send_item(mpsm_pkg::MODE_END, 5'd0);
      send_word("zz", mpsm_pkg::MODE_PATTERN);            // left pending at the build
      send_item(mpsm_pkg::MODE_BUILD, 5'd0);
      send_word("ushers", mpsm_pkg::MODE_TEXT);
      send_item(mpsm_pkg::MODE_TEXT, 5'd26);              // no edge anywhere, back to root
      send_item(3'd5, 5'd1);
      send_item(3'd6, 5'd2);
      send_item(3'd7, 5'd31);
      send_word("a", mpsm_pkg::MODE_PATTERN);             // insert after build
      send_word("ha", mpsm_pkg::MODE_TEXT);
      send_item(mpsm_pkg::MODE_END, 5'd0);                // then the empty pattern
      send_item(mpsm_pkg::MODE_END, 5'd0);
      send_item(mpsm_pkg::MODE_BUILD, 5'd0);
      send_word("qa", mpsm_pkg::MODE_TEXT);
      send_item(mpsm_pkg::MODE_CLEAR, 5'd0);
      drain();

      // random phases: no idling, sender idle, receiver stall, both
      random_session(90);
      drain();
      send_idle_pct = 57;
      random_session(90);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 57;
      hold_off_req = 1;                         // sender keeps offering meanwhile
      random_session(90);
      drain();
      send_idle_pct = 10;
      recv_stall_pct = 10;
      random_session(90);
      drain();

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
sv/mpsm_pkg.sv
sv/multi_pattern_string_matcher.sv
sv/mpsm_checker.sv
sim/mpsm_checker.sv
sim/testbench.sv
